>>> rtl/lsr_pkg.sv
`default_nettype none

package lsr_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;
    localparam int DEPTH_W     = 7;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_CHANGE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd                      cmd;
        logic signed [DATA_W-1:0]  value;
        logic signed [DATA_W-1:0]  new_value;
    } t_in;

    typedef struct packed {
        t_status                   status;
        logic signed [DATA_W-1:0]  data;
        logic [DEPTH_W-1:0]        depth;
    } t_out;

endpackage

`default_nettype wire

>>> rtl/lsr_ram.sv
`default_nettype none

module lsr_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/lifo_stack_with_replace.sv
`default_nettype none

// channel   dir  valid        stall         payload
// request   in   i_in_valid   o_in_stall    i_in  (lsr_pkg::t_in)
// result    out  o_out_valid  i_out_stall   o_out (lsr_pkg::t_out)
//
// One request at a time. Push and an empty or full error go straight to the
// finish state, pop/peek pass through a RAM read state first, and change walks
// entries from the top down, one RAM read per cycle, until a match or the bottom.
// Synchronous active-low reset clears the count and control; store contents
// are undefined until pushed. The result register accepts a new result in the
// cycle its old one is taken; a stalled result holds the block in its
// finish state.

module lifo_stack_with_replace (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire lsr_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output lsr_pkg::t_out      o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_SCAN,
        S_FIN
    } t_state;

    t_state                          r_state, n_state;
    logic [lsr_pkg::CNT_W-1:0]       r_count, n_count;
    logic [lsr_pkg::ADDR_W-1:0]      r_idx, n_idx;
    lsr_pkg::t_in                    r_req, n_req;
    lsr_pkg::t_status                r_status, n_status;
    logic [lsr_pkg::DATA_W-1:0]      r_data, n_data;
    lsr_pkg::t_out                   r_out, n_out;
    logic                            r_out_valid, n_out_valid;

    logic                            ram_we;
    logic [lsr_pkg::ADDR_W-1:0]      ram_waddr, ram_raddr;
    logic [lsr_pkg::DATA_W-1:0]      ram_wdata, ram_rdata;

    logic                            in_acc;
    logic                            out_free;
    logic                            is_empty, is_full;
    logic [lsr_pkg::CNT_W-1:0]       cnt_m1;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign is_empty    = (r_count == '0);
    assign is_full     = (r_count == lsr_pkg::CNT_W'(lsr_pkg::STACK_DEPTH));
    assign cnt_m1      = r_count - lsr_pkg::CNT_W'(1);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    lsr_ram #(
        .WIDTH (lsr_pkg::DATA_W),
        .DEPTH (lsr_pkg::STACK_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_req       = r_req;
        n_status    = r_status;
        n_data      = r_data;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = r_req.new_value;
        ram_raddr   = cnt_m1[lsr_pkg::ADDR_W-1:0];

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_req    = i_in;
                    n_data   = '0;
                    n_status = lsr_pkg::ST_OK;
                    unique case (i_in.cmd) inside
                        lsr_pkg::CMD_PUSH: begin
                            n_state = S_FIN;
                            if (is_full) begin
                                n_status = lsr_pkg::ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[lsr_pkg::ADDR_W-1:0];
                                ram_wdata = i_in.value;
                                n_count   = r_count + lsr_pkg::CNT_W'(1);
                            end
                        end
                        lsr_pkg::CMD_POP, lsr_pkg::CMD_PEEK: begin
                            if (is_empty) begin
                                n_status = lsr_pkg::ST_EMPTY;
                                n_state  = S_FIN;
                            end else begin
                                n_state = S_RD;
                                if (i_in.cmd == lsr_pkg::CMD_POP) begin
                                    n_count = cnt_m1;
                                end
                            end
                        end
                        lsr_pkg::CMD_CHANGE: begin
                            if (is_empty) begin
                                n_status = lsr_pkg::ST_EMPTY;
                                n_state  = S_FIN;
                            end else begin
                                n_idx   = cnt_m1[lsr_pkg::ADDR_W-1:0];
                                n_state = S_SCAN;
                            end
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_RD: begin
                n_data  = ram_rdata;
                n_state = S_FIN;
            end
            S_SCAN: begin
                // ram_rdata holds entry r_idx, read in the previous cycle
                if (ram_rdata == r_req.value) begin
                    ram_we  = 1'b1;
                    n_state = S_FIN;
                end else if (r_idx == '0) begin
                    n_status = lsr_pkg::ST_NOTFOUND;
                    n_state  = S_FIN;
                end else begin
                    n_idx     = r_idx - lsr_pkg::ADDR_W'(1);
                    ram_raddr = n_idx;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out.status = r_status;
                    n_out.data   = r_data;
                    n_out.depth  = lsr_pkg::DEPTH_W'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx    <= n_idx;
        r_req    <= n_req;
        r_status <= n_status;
        r_data   <= n_data;
        r_out    <= n_out;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lsr_pkg::CNT_W'(lsr_pkg::STACK_DEPTH))
        else $error("entry count above store depth");

    a_full_push_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.cmd == lsr_pkg::CMD_PUSH && is_full) |=> is_full)
        else $error("push on full store changed the count");

    a_we_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_IDLE || r_state == S_SCAN))
        else $error("store written outside push or change");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == lsr_pkg::ST_EMPTY)
            |-> (o_out.data == '0 && o_out.depth == '0))
        else $error("empty result carries data or depth");

    a_result_on_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("finished request did not produce a result");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
module tb_top;

    localparam int QUIET_LIMIT = 2000;   // cycles with no handshake on either side
    localparam int TAIL_CYCLES = 80;     // longer than a full-depth change walk

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    lsr_pkg::t_in  i_in        = '0;
    logic          i_out_stall = 1'b0;
    logic          o_in_stall;
    logic          o_out_valid;
    lsr_pkg::t_out o_out;

    lifo_stack_with_replace uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the stack contents
    logic signed [lsr_pkg::DATA_W-1:0] stack_image [lsr_pkg::STACK_DEPTH];
    int            image_count   = 0;
    lsr_pkg::t_out expected_results [$];
    int            error_count   = 0;
    bit            calm          = 1'b0;
    bit            growing       = 1'b1;
    int            send_idle_pct = 20;

    function automatic lsr_pkg::t_out predict_result(lsr_pkg::t_in req);
        lsr_pkg::t_out res;
        res.status = lsr_pkg::ST_OK;
        res.data   = '0;
        case (req.cmd) inside
            lsr_pkg::CMD_PUSH: begin
                if (image_count >= lsr_pkg::STACK_DEPTH) begin
                    res.status = lsr_pkg::ST_FULL;
                end else begin
                    stack_image[lsr_pkg::ADDR_W'(image_count)] = req.value;
                    image_count++;
                end
            end
            lsr_pkg::CMD_POP, lsr_pkg::CMD_PEEK: begin
                if (image_count == 0) begin
                    res.status = lsr_pkg::ST_EMPTY;
                end else begin
                    res.data = stack_image[lsr_pkg::ADDR_W'(image_count - 1)];
                    if (req.cmd == lsr_pkg::CMD_POP)
                        image_count--;
                end
            end
            lsr_pkg::CMD_CHANGE: begin
                if (image_count == 0) begin
                    res.status = lsr_pkg::ST_EMPTY;
                end else begin
                    res.status = lsr_pkg::ST_NOTFOUND;
                    // topmost match only
                    for (int i = image_count - 1; i >= 0; i--) begin
                        if (stack_image[lsr_pkg::ADDR_W'(i)] == req.value) begin
                            stack_image[lsr_pkg::ADDR_W'(i)] = req.new_value;
                            res.status = lsr_pkg::ST_OK;
                            break;
                        end
                    end
                end
            end
        endcase
        res.depth = image_count[lsr_pkg::DEPTH_W-1:0];
        return res;
    endfunction

    function automatic logic signed [lsr_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7fff_ffff;
                    2:       return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            1, 2, 3, 4: return int'($urandom_range(0, 7)) - 4;
            default:    return $urandom();
        endcase
    endfunction

    // mostly a value that is held, so change finds a match
    function automatic logic signed [lsr_pkg::DATA_W-1:0] pick_target();
        if (image_count > 0 && $urandom_range(0, 9) < 7)
            return stack_image[lsr_pkg::ADDR_W'($urandom_range(0, image_count - 1))];
        return pick_value();
    endfunction

    task automatic send_request(input lsr_pkg::t_cmd cmd,
                                input logic signed [lsr_pkg::DATA_W-1:0] value,
                                input logic signed [lsr_pkg::DATA_W-1:0] new_value);
        lsr_pkg::t_in req;
        req.cmd       = cmd;
        req.value     = value;
        req.new_value = new_value;
        if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in       <= req;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results.push_back(predict_result(req));
    endtask

    task automatic settle_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_request();
        int roll;
        if (image_count >= lsr_pkg::STACK_DEPTH && $urandom_range(0, 3) == 0)
            growing = 1'b0;
        else if (image_count == 0 && $urandom_range(0, 3) == 0)
            growing = 1'b1;
        else if ($urandom_range(0, 49) == 0)
            growing = !growing;
        roll = $urandom_range(0, 99);
        if (roll < (growing ? 55 : 25))
            send_request(lsr_pkg::CMD_PUSH, pick_value(), $urandom());
        else if (roll < (growing ? 70 : 65))
            send_request(lsr_pkg::CMD_POP, $urandom(), $urandom());
        else if (roll < (growing ? 80 : 78))
            send_request(lsr_pkg::CMD_PEEK, $urandom(), $urandom());
        else
            send_request(lsr_pkg::CMD_CHANGE, pick_target(), pick_value());
    endtask

    task automatic test_directed();
        send_request(lsr_pkg::CMD_POP, $urandom(), $urandom());
        send_request(lsr_pkg::CMD_PEEK, $urandom(), $urandom());
        send_request(lsr_pkg::CMD_CHANGE, $urandom(), $urandom());
        send_request(lsr_pkg::CMD_PUSH, 32'sh8000_0000, $urandom());
        send_request(lsr_pkg::CMD_PUSH, 32'sh7fff_ffff, $urandom());
        send_request(lsr_pkg::CMD_PUSH, 32'sd0, $urandom());
        send_request(lsr_pkg::CMD_PUSH, -32'sd1, $urandom());
        send_request(lsr_pkg::CMD_PUSH, 32'sh5555_5555, $urandom());
        send_request(lsr_pkg::CMD_PUSH, 32'shaaaa_aaaa, $urandom());
        send_request(lsr_pkg::CMD_PEEK, $urandom(), $urandom());
        // duplicate values: only the upper 7 gets replaced
        send_request(lsr_pkg::CMD_PUSH, 32'sd7, $urandom());
        send_request(lsr_pkg::CMD_PUSH, 32'sd9, $urandom());
        send_request(lsr_pkg::CMD_PUSH, 32'sd7, $urandom());
        send_request(lsr_pkg::CMD_CHANGE, 32'sd7, 32'sd100);
        send_request(lsr_pkg::CMD_CHANGE, 32'sd12345, 32'sd1);
        // match at the very bottom
        send_request(lsr_pkg::CMD_CHANGE, 32'sh8000_0000, 32'sh7fff_fffe);
        repeat (9) send_request(lsr_pkg::CMD_POP, $urandom(), $urandom());
        send_request(lsr_pkg::CMD_POP, $urandom(), $urandom());
    endtask

    task automatic test_fill_and_drain();
        while (image_count < lsr_pkg::STACK_DEPTH)
            send_request(lsr_pkg::CMD_PUSH, pick_value(), $urandom());
        repeat (3) send_request(lsr_pkg::CMD_PUSH, $urandom(), $urandom());
        send_request(lsr_pkg::CMD_PEEK, $urandom(), $urandom());
        send_request(lsr_pkg::CMD_CHANGE, stack_image[0], $urandom());
        send_request(lsr_pkg::CMD_CHANGE, $urandom(), $urandom());
        send_request(lsr_pkg::CMD_CHANGE, pick_target(), $urandom());
        while (image_count > 0)
            send_request(lsr_pkg::CMD_POP, $urandom(), $urandom());
        send_request(lsr_pkg::CMD_POP, $urandom(), $urandom());
        send_request(lsr_pkg::CMD_CHANGE, $urandom(), $urandom());
    endtask

    task automatic test_paused_sender();
        repeat (10) begin
            repeat ($urandom_range(1, 6)) send_random_request();
            settle_results();
        end
    endtask

    task automatic test_random_mix(input int count);
        for (int n = 0; n < count; n++) begin
            send_random_request();
            if (n % 250 == 249)
                settle_results();
        end
    endtask

    task automatic test_steady_stream(input int count);
        calm = 1'b1;
        repeat (count) send_random_request();
    endtask

    // receiver: stall bursts mixed with free-running stretches
    int stall_left = 0;
    bit stalling   = 1'b0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else begin
            stalling   = ($urandom_range(0, 3) == 0);
            stall_left = stalling ? $urandom_range(1, 15) : $urandom_range(1, 40);
        end
        i_out_stall <= stalling && !calm;
    end

    always @(posedge i_clk) begin
        lsr_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result: status %0d data %0d depth %0d",
                         $time, o_out.status, o_out.data, o_out.depth);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_out.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_out.status);
                    error_count++;
                end
                if (o_out.data !== want.data) begin
                    $display("%0t: data expected %0d actual %0d",
                             $time, want.data, o_out.data);
                    error_count++;
                end
                if (o_out.depth !== want.depth) begin
                    $display("%0t: depth expected %0d actual %0d",
                             $time, want.depth, o_out.depth);
                    error_count++;
                end
            end
        end
    end

    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        send_idle_pct = 30;
        test_fill_and_drain();
        send_idle_pct = 0;
        test_fill_and_drain();
        send_idle_pct = 20;
        test_paused_sender();
        send_idle_pct = 15;
        test_random_mix(1350);
        test_steady_stream(200);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
